// ===== hw/rtl/stba_pkg.sv =====
// stba_pkg: shared types, constants and codes of the slot table bump allocator
// used by stba_cell and slot_table_bump_allocator; depends on nothing
package stba_pkg;

    localparam int SLOT_COUNT   = 10;
    localparam int OFFSET_BITS  = 22;
    localparam int ADDR_BITS    = 32;
    localparam int SIZE_BITS    = 22;
    localparam int REGION_BITS  = 22;
    localparam int CFG_IDX_BITS = 2;
    localparam int CAUSE_BITS   = 2;
    // rounded size can reach 2^SIZE_BITS
    localparam int ROUND_BITS   = SIZE_BITS + 1;
    localparam int SUM_BITS     =
        ((OFFSET_BITS > ROUND_BITS) ? OFFSET_BITS : ROUND_BITS) + 1;

    localparam logic [ADDR_BITS-1:0]   BASE_RESET   = 32'h6000_0000;
    localparam logic [REGION_BITS-1:0] REGION_RESET = 22'(2 * 1024 * 1024);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CAUSE_BITS-1:0] CAUSE_NONE   = 2'd0;
    localparam logic [CAUSE_BITS-1:0] CAUSE_FULL   = 2'd1;
    localparam logic [CAUSE_BITS-1:0] CAUSE_NOSLOT = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION = 2'd1;

    // token handed from cell to cell during a scan
    typedef struct packed {
        logic                   valid;
        logic                   op;
        logic [OFFSET_BITS-1:0] top;
        logic                   found;
        logic                   matched;
    } t_carry;

    // write into the slot picked during the last scan
    typedef struct packed {
        logic                   valid;
        logic [OFFSET_BITS-1:0] start_ofs;
        logic [OFFSET_BITS-1:0] end_ofs;
    } t_commit;

endpackage

// ===== hw/rtl/slot_table_bump_allocator.sv =====
// slot_table_bump_allocator: top level, request control, result register, config
// depends on stba_pkg and stba_cell
//
// Bump allocator over a fixed external region with a table of SLOT_COUNT slots.
// Each request is one at a time: after it is taken a token walks down a row of
// SLOT_COUNT cells, one cell per cycle, collecting the highest used end offset
// and the first free slot (allocate) or releasing every slot whose address
// matches (free). An allocate that fits is written into the picked slot as the
// token leaves the last cell. The result then passes through a pending register
// into the output register. The input stalls from acceptance until the pending
// result has moved into the output register, so a new request is taken only
// once the previous one is through the cell row. The finished result sits in an
// output register, so the next request may be taken while the previous result
// is still stalled.
// Allocate sizes are rounded up to even and the capacity check uses the
// rounded size. Configuration writes are always ready; write them only while
// no request is in flight.
module slot_table_bump_allocator
    import stba_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic [SIZE_BITS-1:0]    i_size_bytes,
    input  logic [ADDR_BITS-1:0]    i_release_address,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ADDR_BITS-1:0]    o_granted_address,
    output logic                    o_success,
    output logic [CAUSE_BITS-1:0]   o_fail_cause,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ADDR_BITS-1:0]    i_cfg_data
);

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;

    // configuration registers
    logic [ADDR_BITS-1:0]   r_base;
    logic [REGION_BITS-1:0] r_region;

    // latched request
    logic                   r_op;
    logic [ROUND_BITS-1:0]  r_rounded;
    logic [ADDR_BITS-1:0]   r_addr;
    logic                   r_go;

    // pending and output result
    logic [ADDR_BITS-1:0]   r_pend_addr;
    logic                   r_pend_ok;
    logic [CAUSE_BITS-1:0]  r_pend_cause;
    logic                   r_out_valid;
    logic [ADDR_BITS-1:0]   r_out_addr;
    logic                   r_out_ok;
    logic [CAUSE_BITS-1:0]  r_out_cause;

    logic                   in_accept;
    logic                   out_free;
    logic                   scan_done;
    logic [ROUND_BITS-1:0]  size_plus1;
    logic [SUM_BITS-1:0]    sum;
    logic                   full;
    t_carry                 tail;
    t_commit                commit;
    logic [ADDR_BITS-1:0]   res_addr;
    logic                   res_ok;
    logic [CAUSE_BITS-1:0]  res_cause;

    // cell row
    t_carry                 chain [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0]  picks;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // round up to even
    assign size_plus1 = ROUND_BITS'(i_size_bytes) + ROUND_BITS'(1);

    // token launch into the first cell
    always_comb begin
        chain[0].valid   = r_go;
        chain[0].op      = r_op;
        chain[0].top     = '0;
        chain[0].found   = 1'b0;
        chain[0].matched = 1'b0;
    end

    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        stba_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_carry  (chain[k]),
            .i_commit (commit),
            .i_base   (r_base),
            .i_addr   (r_addr),
            .o_carry  (chain[k+1]),
            .o_pick   (picks[k])
        );
    end

    assign tail      = chain[SLOT_COUNT];
    assign scan_done = tail.valid;

    // capacity check on the rounded size against the highest used end
    assign sum  = SUM_BITS'(tail.top) + SUM_BITS'(r_rounded);
    assign full = sum > SUM_BITS'(r_region);

    always_comb begin
        commit.valid     = scan_done && (tail.op == OP_ALLOC) && !full && tail.found;
        commit.start_ofs = tail.top;
        commit.end_ofs   = sum[OFFSET_BITS-1:0];
    end

    always_comb begin
        res_addr  = '0;
        res_ok    = 1'b0;
        res_cause = CAUSE_NONE;
        if (tail.op == OP_ALLOC) begin
            if (full) begin
                res_cause = CAUSE_FULL;
            end else if (!tail.found) begin
                res_cause = CAUSE_NOSLOT;
            end else begin
                res_addr = r_base + ADDR_BITS'(tail.top);
                res_ok   = 1'b1;
            end
        end else begin
            res_ok = tail.matched;
            if (!tail.matched) begin
                res_cause = CAUSE_NOSLOT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= BASE_RESET;
            r_region    <= REGION_RESET;
        end else begin
            r_state <= n_state;
            r_go    <= in_accept;
            if ((r_state == ST_PEND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:   r_base   <= i_cfg_data;
                    CFG_REGION: r_region <= i_cfg_data[REGION_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= i_opcode;
            r_rounded <= {size_plus1[ROUND_BITS-1:1], 1'b0};
            r_addr    <= i_release_address;
        end
        if (scan_done) begin
            r_pend_addr  <= res_addr;
            r_pend_ok    <= res_ok;
            r_pend_cause <= res_cause;
        end
        if ((r_state == ST_PEND) && out_free) begin
            r_out_addr  <= r_pend_addr;
            r_out_ok    <= r_pend_ok;
            r_out_cause <= r_pend_cause;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_success         = r_out_ok;
    assign o_fail_cause      = r_out_cause;

`ifndef ASSERT_OFF
    // a claim goes to exactly one slot
    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit.valid |-> $onehot(picks))
        else $error("claim without exactly one picked slot");

    // an accepted request launches a token into the cell row
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> chain[0].valid)
        else $error("accepted request did not launch a scan");

    // the scan finishes only while the controller waits for it
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == ST_SCAN))
        else $error("scan finished outside scan state");

    // a delivered result without failure cause is a success
    a_cause_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_fail_cause == CAUSE_NONE)) |-> o_success)
        else $error("result has no cause but no success");
`endif

endmodule

// ===== hw/rtl/stba_cell.sv =====
// stba_cell: one slot of the allocator table with its share of the scan
// depends on stba_pkg
module stba_cell
    import stba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_carry               i_carry,
    input  t_commit              i_commit,
    input  logic [ADDR_BITS-1:0] i_base,
    input  logic [ADDR_BITS-1:0] i_addr,
    output t_carry               o_carry,
    output logic                 o_pick
);

    logic                   r_used;
    logic                   n_used;
    logic                   r_pick;
    logic                   n_pick;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_end;
    t_carry                 r_carry;
    t_carry                 n_carry;
    logic                   hit;

    assign hit = r_used && ((i_base + ADDR_BITS'(r_start)) == i_addr);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.valid) begin
            if (i_carry.op == OP_ALLOC) begin
                if (r_used && (r_end > i_carry.top)) begin
                    n_carry.top = r_end;
                end
                if (!r_used) begin
                    n_carry.found = 1'b1;
                end
            end else if (hit) begin
                n_carry.matched = 1'b1;
            end
        end
    end

    always_comb begin
        n_pick = r_pick;
        if (i_carry.valid) begin
            n_pick = !r_used && !i_carry.found;
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_commit.valid && r_pick) begin
            n_used = 1'b1;
        end else if (i_carry.valid && (i_carry.op == OP_FREE) && hit) begin
            n_used = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_pick  <= 1'b0;
            r_carry <= '0;
        end else begin
            r_used  <= n_used;
            r_pick  <= n_pick;
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit.valid && r_pick) begin
            r_start <= i_commit.start_ofs;
            r_end   <= i_commit.end_ofs;
        end
    end

    assign o_carry = r_carry;
    assign o_pick  = r_pick;

endmodule
